// ----- rtl/assert_macros.svh -----
// Assertion macros for the top level, which checks its own logic with them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clk, quiet during reset.
`define SSA_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, sampled on clk, quiet during reset.
`define SSA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`endif

// ----- rtl/ssa_pkg.sv -----
// Types, codes and defaults shared by the accumulator modules.
package ssa_pkg;
	localparam int DEF_MAX_SAMPLES = 32;
	localparam int DEF_FRAC_BITS   = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam logic [30:0] CAP31  = 31'h7FFF_FFFF;
	localparam logic [31:0] CAP32  = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_DIGIT   = 2'd0,
		CMD_SUBSTEP = 2'd1,
		CMD_READ    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_LEN   = 2'd1,
		ST_OVF   = 2'd2,
		ST_RANGE = 2'd3
	} stat_t;

	typedef enum logic {BK_IDLE, BK_MATH} bk_state_t;

	typedef enum logic [2:0] {
		M_IDLE, M_DIVM, M_MUL, M_DIV1, M_DIV2, M_SQRT, M_DONE
	} math_state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [4:0]  idx;
		logic [5:0]  count;
		logic [63:0] add1;
		logic [63:0] add2;
		logic [31:0] trig;
	} item_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [30:0] mean;
		logic [30:0] rms;
	} math_res_t;
endpackage

// ----- rtl/ssa_front.sv -----
// Front end: accept beats, form addends, drop idle commands, queue items.
module ssa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_cmd,
	input  logic [185:0]        in_data,
	input  logic                pop,
	output logic                empty,
	output ssa_pkg::item_t      head
);
	import ssa_pkg::*;
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	item_t           nitem;
	logic            push;
	logic [14:0]     value;
	logic [29:0]     value_sq;

	assign in_ready = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head     = mem_q[rp_q];
	assign value    = in_data[25:11];
	assign value_sq = {15'd0, value} * {15'd0, value};
	assign push     = in_valid && in_ready && (cmd_t'(in_cmd) != CMD_NONE);

	always_comb begin
		nitem.cmd   = cmd_t'(in_cmd);
		nitem.idx   = in_data[4:0];
		nitem.count = in_data[10:5];
		nitem.trig  = in_data[185:154];
		if (cmd_t'(in_cmd) == CMD_DIGIT) begin
			nitem.add1 = 64'(value);
			nitem.add2 = 64'(value_sq);
		end else begin
			nitem.add1 = in_data[89:26];
			nitem.add2 = in_data[153:90];
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= nitem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(QUEUE_DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(QUEUE_DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

// ----- rtl/ssa_math.sv -----
// Iterative mean and rms unit: bit-serial divide, multiply and square root.
module ssa_math #(
	parameter int FRAC_BITS = ssa_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               ack,
	input  logic [63:0]        sum,
	input  logic [63:0]        sum2,
	input  logic [31:0]        n,
	output ssa_pkg::math_res_t res
);
	import ssa_pkg::*;
	localparam int DW = 96 + 2*FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	math_state_t    state_q, state_d;
	logic [CW-1:0]  cnt_q;
	logic [DW-1:0]  a_q;
	logic [DW-1:0]  quo;
	logic [31:0]    rem_q, n_q, nr_q;
	logic [32:0]    trial;
	logic           qbit;
	logic [127:0]   qacc_q, qm_q;
	logic [95:0]    pacc_q, pm_q;
	logic [63:0]    qmr_q, v_q, root_q, bit_q, rb;
	logic [30:0]    mean_q, rms_q;
	logic           last;
	logic           p_le_q;

	assign last   = (cnt_q == '0);
	assign trial  = {rem_q, a_q[DW-1]};
	assign qbit   = (trial >= {1'b0, n_q});
	// full quotient once the current bit is shifted in
	assign quo    = {a_q[DW-2:0], qbit};
	assign p_le_q = ({32'd0, pacc_q} <= qacc_q);
	assign rb     = root_q + bit_q;

	assign res.busy = (state_q != M_IDLE);
	assign res.done = (state_q == M_DONE);
	assign res.mean = mean_q;
	assign res.rms  = rms_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			M_IDLE: if (start) state_d = M_DIVM;
			M_DIVM: if (last) state_d = M_MUL;
			M_MUL:  if (last) state_d = p_le_q ? M_DONE : M_DIV1;
			M_DIV1: if (last) state_d = M_DIV2;
			M_DIV2: if (last) state_d = (|quo[DW-1:62]) ? M_DONE : M_SQRT;
			M_SQRT: if (last) state_d = M_DONE;
			M_DONE: if (ack) state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= M_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				a_q    <= DW'(sum) << FRAC_BITS;
				rem_q  <= '0;
				n_q    <= n;
				nr_q   <= n;
				cnt_q  <= CW'(DW-1);
				qacc_q <= '0;
				pacc_q <= '0;
				qm_q   <= 128'(sum);
				pm_q   <= 96'(sum2);
				qmr_q  <= sum;
			end
			M_DIVM, M_DIV1, M_DIV2: begin
				// one restoring quotient bit per cycle
				rem_q <= qbit ? 32'(trial - {1'b0, n_q}) : trial[31:0];
				a_q   <= {a_q[DW-2:0], qbit};
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					rem_q <= '0;
					cnt_q <= CW'(DW-1);
					if (state_q == M_DIVM) begin
						mean_q <= (|quo[DW-1:31]) ? CAP31 : quo[30:0];
						// one pass per multiplier bit, then one to settle the sums
						cnt_q  <= CW'(64);
						rms_q  <= '0;
					end
					if (state_q == M_DIV2) begin
						rms_q  <= CAP31;
						v_q    <= {2'b00, quo[61:0]};
						root_q <= '0;
						bit_q  <= 64'd1 << 62;
						cnt_q  <= CW'(31);
					end
				end
			end
			M_MUL: begin
				if (qmr_q[0]) qacc_q <= qacc_q + qm_q;
				if (nr_q[0])  pacc_q <= pacc_q + pm_q;
				qm_q  <= qm_q << 1;
				pm_q  <= pm_q << 1;
				qmr_q <= qmr_q >> 1;
				nr_q  <= nr_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					a_q   <= DW'(pacc_q - qacc_q[95:0]) << (2*FRAC_BITS);
					cnt_q <= CW'(DW-1);
				end
			end
			M_SQRT: begin
				if (v_q >= rb) begin
					v_q    <= v_q - rb;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 1'b1;
				if (last) rms_q <= (v_q >= rb) ? 31'((root_q >> 1) + bit_q)
				                               : 31'(root_q >> 1);
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/ssa_back.sv -----
// Back end: slot sums, trigger total, vector checks and the output register.
module ssa_back #(
	parameter int MAX_SAMPLES = ssa_pkg::DEF_MAX_SAMPLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  ssa_pkg::item_t     head,
	output logic               pop,
	output logic               math_start,
	output logic               math_ack,
	output logic [63:0]        math_sum,
	output logic [63:0]        math_sum2,
	output logic [31:0]        math_n,
	input  ssa_pkg::math_res_t math_res,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic [99:0]        out_data
);
	import ssa_pkg::*;
	localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	logic [63:0]   sums_q [MAX_SAMPLES];
	logic [63:0]   sqs_q  [MAX_SAMPLES];
	logic [31:0]   trig_q, trig_new;
	logic [5:0]    len_q, len_new;
	stat_t         vstat_q, vs_start, vs_new, err, stat_o_q;
	bk_state_t     state_q, state_d;
	logic          oval_q, can_load, is_read, rd_err, in_range, last, load, do_write;
	logic [5:0]    idx6;
	logic [IW-1:0] slot;
	logic [63:0]   cur_sum, cur_sq;
	logic [32:0]   tsum;
	logic [30:0]   mean_o_q, rms_o_q;

	assign idx6     = {1'b0, head.idx};
	assign slot     = IW'(idx6);
	assign in_range = (7'(head.idx) < 7'(MAX_SAMPLES));
	assign cur_sum  = in_range ? sums_q[slot] : '0;
	assign cur_sq   = in_range ? sqs_q[slot] : '0;
	assign is_read  = (head.cmd == CMD_READ);
	assign rd_err   = (trig_q == '0) || (idx6 >= len_q) || !in_range;
	assign can_load = !oval_q || out_ready;
	assign last     = (idx6 + 6'd1 == head.count);

	always_comb begin
		vs_start = (head.idx == '0) ? ST_OK : vstat_q;
		len_new  = len_q;
		err      = ST_OK;
		if (len_q == '0) begin
			if (head.count == '0 || 7'(head.count) > 7'(MAX_SAMPLES)) err = ST_LEN;
			else len_new = head.count;
		end else if (head.count != len_q) begin
			err = ST_LEN;
		end
		if (err == ST_OK && (idx6 >= len_new || !in_range)) err = ST_RANGE;
		if (err == ST_OK && (cur_sum >= ~head.add1 || cur_sq >= ~head.add2)) err = ST_OVF;
		do_write = (err == ST_OK);
		vs_new   = (err != ST_OK && vs_start == ST_OK) ? err : vs_start;
		tsum     = 33'(trig_q) + ((head.cmd == CMD_DIGIT) ? 33'd1 : 33'(head.trig));
		trig_new = trig_q;
		if (last && vs_new == ST_OK) trig_new = tsum[32] ? CAP32 : tsum[31:0];
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		math_start = 1'b0;
		math_ack   = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop = !empty && can_load;
				if (pop && is_read && !rd_err) begin
					math_start = 1'b1;
					state_d    = BK_MATH;
				end else begin
					load = pop;
				end
			end
			BK_MATH: begin
				if (math_res.done && can_load) begin
					math_ack = 1'b1;
					load     = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign math_sum  = cur_sum;
	assign math_sum2 = cur_sq;
	assign math_n    = trig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			oval_q  <= 1'b0;
			trig_q  <= '0;
			len_q   <= '0;
			vstat_q <= ST_OK;
			for (int i = 0; i < MAX_SAMPLES; i++) begin
				sums_q[i] <= '0;
				sqs_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load)           oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
			if (pop && !is_read) begin
				vstat_q <= vs_new;
				len_q   <= len_new;
				trig_q  <= trig_new;
				if (do_write) begin
					sums_q[slot] <= cur_sum + head.add1;
					sqs_q[slot]  <= cur_sq + head.add2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == BK_MATH) begin
				stat_o_q <= ST_OK;
				mean_o_q <= math_res.mean;
				rms_o_q  <= math_res.rms;
			end else begin
				stat_o_q <= is_read ? ST_RANGE : vs_new;
				mean_o_q <= '0;
				rms_o_q  <= '0;
			end
		end
	end

	// trigger total and length after the step: the state registers themselves
	assign out_valid  = oval_q;
	assign out_status = stat_o_q;
	assign out_data   = {len_q, trig_q, rms_o_q, mean_o_q};
endmodule

// ----- rtl/sample_sum_and_square_accumulator_unit.sv -----
// Top level of the sample sum and square accumulator.
// Keeps a 64-bit sum and sum of squares per sample slot plus a saturating
// trigger total, and answers reads with the mean and rms of one slot in
// unsigned fixed point with FRAC_BITS fraction bits. The front end takes one
// beat per cycle while not full into a four-entry queue; command 3 is taken
// and dropped with no result. Add beats (digit and substep) leave the queue
// at one per cycle and give their result beat in the next cycle, so a stream
// of adds runs at one beat per cycle while the result side keeps up. A read
// that finds no triggers or a slot out of range also answers at once with
// status 3. A valid read runs the shared bit-serial unit: a divide for the
// mean, a shift-add multiply, two more divides and a square root, stopping
// early if the variance is not positive or too large; adds behind it wait in
// the queue. Trigger total and length in a result are those after its step.
module sample_sum_and_square_accumulator_unit #(
	parameter int MAX_SAMPLES = ssa_pkg::DEF_MAX_SAMPLES,
	parameter int FRAC_BITS   = ssa_pkg::DEF_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sample_index, sample_count, sample_value, sum_in, square_sum_in,
	// trigger_count_in, then zero fill
	input  logic [191:0] s_tdata,
	// command
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// mean_value, rms_value, trigger_total, length_in_use, then zero fill
	output logic [103:0] m_tdata,
	// status
	output logic [1:0]   m_tuser
);
	import ssa_pkg::*;

	logic        q_empty, q_pop, math_start, math_ack;
	item_t       q_head;
	logic [63:0] math_sum, math_sum2;
	logic [31:0] math_n;
	math_res_t   math_res;
	logic [99:0] out_data;

	// front: accept, form addends, queue
	ssa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_data  (s_tdata[185:0]),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// back: state, checks, result beat
	ssa_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (q_head),
		.pop        (q_pop),
		.math_start (math_start),
		.math_ack   (math_ack),
		.math_sum   (math_sum),
		.math_sum2  (math_sum2),
		.math_n     (math_n),
		.math_res   (math_res),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_data   (out_data)
	);

	// shared iterative mean and rms unit
	ssa_math #(.FRAC_BITS(FRAC_BITS)) u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (math_start),
		.ack    (math_ack),
		.sum    (math_sum),
		.sum2   (math_sum2),
		.n      (math_n),
		.res    (math_res)
	);

	assign m_tdata = {4'd0, out_data};

`include "assert_macros.svh"
	// never pop an empty queue
	`SSA_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
	// a read starts only on an idle unit
	`SSA_ASSERT_NOW(a_start_idle, math_start, !math_res.busy, "math unit restarted while busy")
	// a start leaves the unit busy and not yet done
	`SSA_ASSERT_NEXT(a_start_busy, math_start, math_res.busy && !math_res.done, "math unit not busy")
	// length in use never exceeds the slot count
	`SSA_ASSERT_NOW(a_len_max, m_tvalid, 7'(m_tdata[99:94]) <= 7'(MAX_SAMPLES), "length too large")
endmodule
